// File: rtl/core/bvls_pkg.sv
package bvls_pkg;

  localparam int DEF_MAX_BODIES = 256;

  // Configuration register map.
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_MAX_LIN   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_ANG   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SLEEP_LIN = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SLEEP_ANG = 3'd3;
  localparam logic [CFG_AW-1:0] REG_TTS       = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DT        = 3'd5;

  localparam logic [30:0] RST_MAX_LIN   = 31'd13107200;
  localparam logic [30:0] RST_MAX_ANG   = 31'd262144;
  localparam logic [30:0] RST_SLEEP_LIN = 31'd3277;
  localparam logic [30:0] RST_SLEEP_ANG = 31'd2294;
  localparam logic [31:0] RST_TTS       = 32'd32768;
  localparam logic [31:0] RST_DT        = 32'd1092;

  // Iteration counts of the shared square root and divider.
  localparam int CNT_W      = 6;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 64;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_MUL_XX,
    OP_MUL_YY,
    OP_MUL_LL,
    OP_MUL_SS,
    OP_CMP,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_FINISH
  } bvls_op_t;

  typedef struct packed {
    bvls_op_t op;
    logic     sel_y;
  } bvls_cmd_t;

  typedef struct packed {
    logic over_limit;
    logic clear_last;
  } bvls_sts_t;

endpackage

// File: rtl/core/bvls_if.sv
interface bvls_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  body_index;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] ang_vel;
  modport source (output valid, body_index, vel_x, vel_y, ang_vel, input ready);
  modport sink   (input valid, body_index, vel_x, vel_y, ang_vel, output ready);
endinterface

interface bvls_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_index;
  logic [31:0] out_vel_x;
  logic [31:0] out_vel_y;
  logic [31:0] out_ang_vel;
  logic        speed_limited;
  logic [31:0] rest_time;
  logic        fall_asleep;
  modport source (output valid, out_index, out_vel_x, out_vel_y, out_ang_vel,
                  speed_limited, rest_time, fall_asleep, input ready);
  modport sink   (input valid, out_index, out_vel_x, out_vel_y, out_ang_vel,
                  speed_limited, rest_time, fall_asleep, output ready);
endinterface

interface bvls_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [31:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/core/body_velocity_limit_and_sleep.sv
// Channel   Direction  Handshake        Payload
// in_bus    sink       valid / ready    body_index, vel_x, vel_y, ang_vel
// out_bus   source     valid / ready    out_index, out_vel_x, out_vel_y, out_ang_vel,
//                                       speed_limited, rest_time, fall_asleep
// cfg_bus   sink       valid / ready=1  addr (register index), data
//
// One beat is processed at a time. A beat not over the speed limit goes
// straight from the compare to the finish; a limited beat first runs the
// 32-step square root and two 64-step bit-serial divisions on the shared datapath.
// After reset the sleep timer store is cleared one entry a cycle, all of its
// MAX_BODIES entries, while no input beat is taken; configuration writes are.
// A finished result sits in the output register while the next beat is
// accepted; the datapath only stalls at its final step if that register is
// still occupied.
module body_velocity_limit_and_sleep
  import bvls_pkg::*;
#(
  parameter int MAX_BODIES = DEF_MAX_BODIES
) (
  input logic     clk,
  input logic     rst_n,
  bvls_in_if.sink   in_bus,
  bvls_out_if.source out_bus,
  bvls_cfg_if.sink  cfg_bus
);

  bvls_cmd_t cmd;
  bvls_sts_t sts;

  // Register writes always complete; the user must write only when the block is idle; unchecked.
  assign cfg_bus.ready = 1'b1;

  // The controller sequences the multiply, square root and divide steps and
  // owns the input and output handshakes; the datapath holds all arithmetic and the timer store.
  bvls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bvls_dp #(
    .MAX_BODIES (MAX_BODIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_bus.valid),
    .cfg_addr      (cfg_bus.addr),
    .cfg_data      (cfg_bus.data),
    .in_body_index (in_bus.body_index),
    .in_vel_x      (in_bus.vel_x),
    .in_vel_y      (in_bus.vel_y),
    .in_ang_vel    (in_bus.ang_vel),
    .out_index     (out_bus.out_index),
    .out_vel_x     (out_bus.out_vel_x),
    .out_vel_y     (out_bus.out_vel_y),
    .out_ang_vel   (out_bus.out_ang_vel),
    .speed_limited (out_bus.speed_limited),
    .rest_time     (out_bus.rest_time),
    .fall_asleep   (out_bus.fall_asleep)
  );

endmodule

// File: rtl/core/bvls_dp.sv
module bvls_dp
  import bvls_pkg::*;
#(
  parameter int MAX_BODIES = DEF_MAX_BODIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bvls_cmd_t         cmd,
  output bvls_sts_t         sts,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [31:0]       cfg_data,
  input  logic [7:0]        in_body_index,
  input  logic [31:0]       in_vel_x,
  input  logic [31:0]       in_vel_y,
  input  logic [31:0]       in_ang_vel,
  output logic [7:0]        out_index,
  output logic [31:0]       out_vel_x,
  output logic [31:0]       out_vel_y,
  output logic [31:0]       out_ang_vel,
  output logic              speed_limited,
  output logic [31:0]       rest_time,
  output logic              fall_asleep
);

  localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int RSH = 25;
  localparam longint RECIP = ((longint'(1) << RSH) + MAX_BODIES - 1) / MAX_BODIES;

  logic [30:0] max_lin_r, max_ang_r, slp_lin_r, slp_ang_r;
  logic [31:0] tts_r, dt_r;

  logic [7:0]    idx_r;
  logic [31:0]   vx_r, vy_r, w_r, wc_r;
  logic [8:0]    q_r;
  logic [AW-1:0] slot_r, clr_addr_r;
  logic [31:0]   timer_r;
  logic [63:0]   prod_r, sq_r, lim_sq_r;
  logic          sleep_ok_r, limited_r;
  logic [63:0]   x_r, res_r, bit_r;
  logic [32:0]   rem_r;
  logic [31:0]   quo_r, root_r, ox_r, oy_r;
  logic [31:0]   timers_mem [MAX_BODIES];

  logic [31:0] ax, ay, mul_a, mul_b, wabs, wc, qc, sres, tsat, wr_val;
  logic [63:0] mul_p, trial;
  logic [32:0] w33, wmax33, wneg, rem_sh, tsum;
  logic [33:0] sprod;
  logic [25:0] qd;
  logic [8:0]  rem9;
  logic        sq_ge, dge, neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lin_r <= RST_MAX_LIN;
      max_ang_r <= RST_MAX_ANG;
      slp_lin_r <= RST_SLEEP_LIN;
      slp_ang_r <= RST_SLEEP_ANG;
      tts_r     <= RST_TTS;
      dt_r      <= RST_DT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAX_LIN:   max_lin_r <= cfg_data[30:0];
        REG_MAX_ANG:   max_ang_r <= cfg_data[30:0];
        REG_SLEEP_LIN: slp_lin_r <= cfg_data[30:0];
        REG_SLEEP_ANG: slp_ang_r <= cfg_data[30:0];
        REG_TTS:       tts_r     <= cfg_data;
        REG_DT:        dt_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ax = vx_r[31] ? -vx_r : vx_r;
    ay = vy_r[31] ? -vy_r : vy_r;
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_XX: begin mul_a = ax; mul_b = ax; end
      OP_MUL_YY: begin mul_a = ay; mul_b = ay; end
      OP_MUL_LL: begin mul_a = {1'b0, max_lin_r}; mul_b = {1'b0, max_lin_r}; end
      OP_MUL_SS: begin mul_a = {1'b0, slp_lin_r}; mul_b = {1'b0, slp_lin_r}; end
      OP_DIV_INIT: begin
        mul_a = cmd.sel_y ? ay : ax;
        mul_b = {1'b0, max_lin_r};
      end
      default: ;
    endcase
    mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    // Body slot by reciprocal multiply; exact for an 8-bit index.
    sprod = 34'(idx_r) * 34'(RECIP);
    qd    = 26'(q_r) * 26'(MAX_BODIES);
    rem9  = {1'b0, idx_r} - qd[8:0];

    w33    = {w_r[31], w_r};
    wmax33 = {2'b00, max_ang_r};
    wneg   = -wmax33;
    if ($signed(w33) < $signed(wneg)) begin
      wc = wneg[31:0];
    end else if ($signed(w33) > $signed(wmax33)) begin
      wc = wmax33[31:0];
    end else begin
      wc = w_r;
    end
    wabs = wc_r[31] ? -wc_r : wc_r;

    trial = res_r + bit_r;
    sq_ge = x_r >= trial;

    rem_sh = {rem_r[31:0], prod_r[63]};
    dge    = rem_sh >= {1'b0, root_r};

    neg = cmd.sel_y ? vy_r[31] : vx_r[31];
    if (neg) begin
      qc   = (quo_r > 32'h8000_0000) ? 32'h8000_0000 : quo_r;
      sres = -qc;
    end else begin
      qc   = quo_r[31] ? 32'h7FFF_FFFF : quo_r;
      sres = qc;
    end

    tsum   = {1'b0, timer_r} + {1'b0, dt_r};
    tsat   = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
    wr_val = sleep_ok_r ? tsat : 32'd0;

    sts.over_limit = sq_r > lim_sq_r;
    sts.clear_last = clr_addr_r == AW'(MAX_BODIES - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) begin
      timers_mem[clr_addr_r] <= '0;
    end else if (cmd.op == OP_FINISH) begin
      timers_mem[slot_r] <= wr_val;
    end
    if (cmd.op == OP_MUL_LL) begin
      timer_r <= timers_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        idx_r <= in_body_index;
        vx_r  <= in_vel_x;
        vy_r  <= in_vel_y;
        w_r   <= in_ang_vel;
        ox_r  <= in_vel_x;
        oy_r  <= in_vel_y;
      end
      OP_MUL_XX: begin
        prod_r <= mul_p;
        q_r    <= sprod[33:25];
        wc_r   <= wc;
      end
      OP_MUL_YY: begin
        prod_r <= mul_p;
        sq_r   <= prod_r;
        slot_r <= AW'(rem9);
      end
      OP_MUL_LL: begin
        prod_r <= mul_p;
        sq_r   <= sq_r + prod_r;
      end
      OP_MUL_SS: begin
        prod_r   <= mul_p;
        lim_sq_r <= prod_r;
      end
      OP_CMP: begin
        sleep_ok_r <= (sq_r < prod_r) && (wabs < {1'b0, slp_ang_r});
        limited_r  <= sts.over_limit;
        x_r        <= sq_r;
        res_r      <= '0;
        bit_r      <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          x_r   <= x_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DIV_INIT: begin
        prod_r <= mul_p;
        rem_r  <= '0;
        quo_r  <= '0;
        root_r <= (res_r[31:0] == 32'd0) ? 32'd1 : res_r[31:0];
      end
      OP_DIV_STEP: begin
        rem_r  <= dge ? rem_sh - {1'b0, root_r} : rem_sh;
        quo_r  <= {quo_r[30:0], dge};
        prod_r <= {prod_r[62:0], 1'b0};
      end
      OP_DIV_END: begin
        if (cmd.sel_y) begin
          oy_r <= sres;
        end else begin
          ox_r <= sres;
        end
      end
      OP_FINISH: begin
        out_index     <= idx_r;
        out_vel_x     <= ox_r;
        out_vel_y     <= oy_r;
        out_ang_vel   <= wc_r;
        speed_limited <= limited_r;
        rest_time     <= wr_val;
        fall_asleep   <= sleep_ok_r && (tsat >= tts_r);
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/bvls_ctrl.sv
module bvls_ctrl
  import bvls_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bvls_sts_t sts,
  output bvls_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MXX, S_MYY, S_MLL, S_MSS, S_CMP, S_SQRT,
    S_DIVX_INIT, S_DIVX, S_DIVX_END, S_DIVY_INIT, S_DIVY, S_DIVY_END, S_FIN
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.sel_y = 1'b0;
    unique case (state_r)
      S_CLEAR:     cmd.op = OP_CLEAR;
      S_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_MXX:       cmd.op = OP_MUL_XX;
      S_MYY:       cmd.op = OP_MUL_YY;
      S_MLL:       cmd.op = OP_MUL_LL;
      S_MSS:       cmd.op = OP_MUL_SS;
      S_CMP:       cmd.op = OP_CMP;
      S_SQRT:      cmd.op = OP_SQRT_STEP;
      S_DIVX_INIT: cmd.op = OP_DIV_INIT;
      S_DIVX:      cmd.op = OP_DIV_STEP;
      S_DIVX_END:  cmd.op = OP_DIV_END;
      S_DIVY_INIT: begin cmd.op = OP_DIV_INIT; cmd.sel_y = 1'b1; end
      S_DIVY:      cmd.op = OP_DIV_STEP;
      S_DIVY_END:  begin cmd.op = OP_DIV_END; cmd.sel_y = 1'b1; end
      S_FIN:       cmd.op = slot_free ? OP_FINISH : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR:     if (sts.clear_last) state_r <= S_IDLE;
        S_IDLE:      if (in_valid) state_r <= S_MXX;
        S_MXX:       state_r <= S_MYY;
        S_MYY:       state_r <= S_MLL;
        S_MLL:       state_r <= S_MSS;
        S_MSS:       state_r <= S_CMP;
        S_CMP: begin
          cnt_r   <= '0;
          state_r <= sts.over_limit ? S_SQRT : S_FIN;
        end
        S_SQRT: begin
          if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_DIVX_INIT;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_DIVX_INIT: state_r <= S_DIVX;
        S_DIVX: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_r <= S_DIVX_END;
        end
        S_DIVX_END:  state_r <= S_DIVY_INIT;
        S_DIVY_INIT: begin cnt_r <= '0; state_r <= S_DIVY; end
        S_DIVY: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_r <= S_DIVY_END;
        end
        S_DIVY_END:  state_r <= S_FIN;
        S_FIN: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default:     state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MXX))
    else $error("accepted beat did not start the datapath sequence");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FINISH) |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken beat");
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FINISH) |=> out_valid_r)
    else $error("finished result not presented");
  a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT && cnt_r == CNT_W'(SQRT_STEPS - 1)) |=>
      (state_r == S_DIVX_INIT))
    else $error("square root did not end after its step count");
`endif

endmodule
